// File: hw/rtl/assert_macros.svh
// Assertion macros used by the translator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("invariant check failed");

`endif

// File: hw/rtl/tlbpt_pkg.sv
// Shared constants and types of the TLB and page table translator.
package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int FRAME_OUT_W = 8;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_TLB_HIT = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_PT_HIT  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_NEW     = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STATUS_OOF     = STATUS_W'(3);

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_pt_ctrl;

endpackage

// File: hw/rtl/tlbpt_tlb.sv
// Fully associative TLB with parallel tag compare and FIFO insertion.
module tlbpt_tlb #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PAGE_W-1:0]  i_page,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame,
    input  logic               i_ins_en,
    input  logic [PAGE_W-1:0]  i_ins_page,
    input  logic [FRAME_W-1:0] i_ins_frame
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [PAGE_W-1:0]  r_tag [ENTRIES];
    logic [FRAME_W-1:0] r_frm [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_ptr;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] first;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == i_page);
        end
        // Isolate the lowest-numbered match.
        first = match & (~match + ENTRIES'(1));
        o_frame = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            o_frame = o_frame | ({FRAME_W{first[i]}} & r_frm[i]);
        end
    end

    assign o_hit = |match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_ins_en) begin
            r_valid[r_ptr] <= 1'b1;
            if (r_ptr == IDX_W'(ENTRIES - 1)) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins_en) begin
            r_tag[r_ptr] <= i_ins_page;
            r_frm[r_ptr] <= i_ins_frame;
        end
    end

endmodule

// File: hw/rtl/tlbpt_page_table.sv
// Page table memory with valid flag per entry and a clearing sweep after reset.
module tlbpt_page_table #(
    parameter int ENTRIES = 256,
    parameter int FRAME_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tlbpt_pkg::t_pt_ctrl     i_ctrl,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [FRAME_W-1:0]      i_wr_frame,
    output logic                    o_rd_valid,
    output logic [FRAME_W-1:0]      o_rd_frame,
    output logic                    o_busy
);

    import tlbpt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic [FRAME_W:0]   r_mem [ENTRIES];
    logic [FRAME_W:0]   r_rd;
    logic               r_clr_busy;
    logic [IDX_W-1:0]   r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == IDX_W'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= {1'b1, i_wr_frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd[FRAME_W];
    assign o_rd_frame = r_rd[FRAME_W-1:0];
    assign o_busy     = r_clr_busy;

endmodule

// File: hw/rtl/tlb_page_table_translator_top.sv
// Top level of the TLB and page table address translator.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_ready     i_logical_address
//  output    out        o_out_valid / i_out_ready   o_phys_addr, o_frame, o_status
//
// The transfer of an address issues the page table read, and the S_LOOK state
// that follows compares the TLB, decides and writes back.
// The read of the page table memory is synchronous and registered, so the decision waits for S_LOOK.
// After reset a clearing sweep over every page table entry runs before the first transfer.
// A result waiting in the output register stalls only the decision cycle of the next item.
`include "assert_macros.svh"

module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_ENTRIES = 256,
    parameter int FRAME_COUNT  = 256,
    parameter int OFFSET_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0]         i_logical_address,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tlbpt_pkg::ADDR_W-1:0]         o_phys_addr,
    output logic [tlbpt_pkg::FRAME_OUT_W-1:0]    o_frame,
    output logic [tlbpt_pkg::STATUS_W-1:0]       o_status
);

    import tlbpt_pkg::*;

    // A page field of zero width is kept as one bit that always reads zero.
    localparam int PAGE_W  = (OFFSET_BITS < ADDR_W) ? (ADDR_W - OFFSET_BITS) : 1;
    localparam int PIDX_W  = $clog2(PAGE_ENTRIES);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
    localparam bit PE_POW2 = (PAGE_ENTRIES & (PAGE_ENTRIES - 1)) == 0;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic                   r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    logic [CNT_W-1:0]       r_frames_used, n_frames_used;

    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [PIDX_W-1:0]      r_pidx;
    logic [ADDR_W-1:0]      r_out_phys;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    logic [STATUS_W-1:0]    r_out_status;

    logic                   in_xfer;
    logic [PAGE_W-1:0]      in_page;
    logic [PIDX_W-1:0]      in_pidx;

    logic                   pt_busy;
    logic                   pt_valid;
    logic [FRAME_W-1:0]     pt_frame;
    t_pt_ctrl               pt_ctrl;

    logic                   tlb_hit;
    logic [FRAME_W-1:0]     tlb_frame;

    logic                   commit;
    logic                   frame_left;
    logic                   tlb_ins;
    logic                   is_oof;
    logic [FRAME_W-1:0]     res_frame;
    logic [STATUS_W-1:0]    res_status;

    assign o_in_ready = (r_state == S_IDLE) && !pt_busy;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign in_page    = PAGE_W'(i_logical_address >> OFFSET_BITS);

    // Page table index is the page modulo the table depth. For a depth that is
    // not a power of two the quotient comes from a multiply by a reciprocal that
    // is exact over the full page range.
    generate
        if (PE_POW2) begin : g_mask
            assign in_pidx = PIDX_W'(in_page);
        end else begin : g_recip
            localparam int SHIFT   = PAGE_W + PIDX_W;
            localparam int RECIP_W = PAGE_W + 2;
            localparam longint unsigned RECIP =
                ((64'd1 << SHIFT) + PAGE_ENTRIES - 1) / PAGE_ENTRIES;
            localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
            logic [PAGE_W+RECIP_W-1:0] prod;
            logic [PAGE_W-1:0]         quo;
            logic [PAGE_W-1:0]         rem;
            assign prod    = (PAGE_W + RECIP_W)'(in_page) * (PAGE_W + RECIP_W)'(RECIP_V);
            assign quo     = PAGE_W'(prod >> SHIFT);
            assign rem     = in_page - PAGE_W'(quo * PAGE_ENTRIES);
            assign in_pidx = PIDX_W'(rem);
        end
    endgenerate

    // The commit edge of one item always precedes the transfer of the next, so a
    // page table write is visible to the following read without forwarding.
    assign commit     = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);
    assign frame_left = (r_frames_used != CNT_W'(FRAME_COUNT));

    always_comb begin
        res_frame  = '0;
        res_status = STATUS_OOF;
        tlb_ins    = 1'b0;
        is_oof     = 1'b0;
        pt_ctrl.rd_en = in_xfer;
        pt_ctrl.wr_en = 1'b0;
        n_frames_used = r_frames_used;
        if (tlb_hit) begin
            res_frame  = tlb_frame;
            res_status = STATUS_TLB_HIT;
        end else if (pt_valid) begin
            res_frame  = pt_frame;
            res_status = STATUS_PT_HIT;
            tlb_ins    = commit;
        end else if (frame_left) begin
            res_frame     = r_frames_used[FRAME_W-1:0];
            res_status    = STATUS_NEW;
            tlb_ins       = commit;
            pt_ctrl.wr_en = commit;
            if (commit) begin
                n_frames_used = r_frames_used + CNT_W'(1);
            end
        end else begin
            // No frame left: report it and leave every store untouched.
            is_oof = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_frames_used <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_frames_used <= n_frames_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_page   <= in_page;
            r_offset <= OFFSET_BITS'(i_logical_address);
            r_pidx   <= in_pidx;
        end
        if (commit) begin
            r_out_status <= res_status;
            if (is_oof) begin
                r_out_phys  <= '0;
                r_out_frame <= '0;
            end else begin
                r_out_phys  <= ADDR_W'({res_frame, r_offset});
                r_out_frame <= FRAME_OUT_W'(res_frame);
            end
        end
    end

    tlbpt_page_table #(
        .ENTRIES (PAGE_ENTRIES),
        .FRAME_W (FRAME_W)
    ) u_page_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (pt_ctrl),
        .i_rd_addr  (in_pidx),
        .i_wr_addr  (r_pidx),
        .i_wr_frame (r_frames_used[FRAME_W-1:0]),
        .o_rd_valid (pt_valid),
        .o_rd_frame (pt_frame),
        .o_busy     (pt_busy)
    );

    tlbpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W),
        .FRAME_W (FRAME_W)
    ) u_tlb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_page      (r_page),
        .o_hit       (tlb_hit),
        .o_frame     (tlb_frame),
        .i_ins_en    (tlb_ins),
        .i_ins_page  (r_page),
        .i_ins_frame (res_frame)
    );

    assign o_out_valid = r_out_valid;
    assign o_phys_addr = r_out_phys;
    assign o_frame     = r_out_frame;
    assign o_status    = r_out_status;

    // The allocation count never passes the number of frames.
    `ASSERT_ALWAYS(a_frames_bound, i_clk, i_rst_n, r_frames_used <= CNT_W'(FRAME_COUNT))
    // An out-of-frames result carries a zero frame and a zero address.
    `ASSERT_IMPLY(a_oof_zero, i_clk, i_rst_n, o_out_valid && (o_status == STATUS_OOF),
        (o_frame == '0) && (o_phys_addr == '0))
    // The allocation count moves only on the commit of a newly allocated frame.
    `ASSERT_IMPLY(a_alloc_commit, i_clk, i_rst_n,
        $past(i_rst_n) && (r_frames_used != $past(r_frames_used)),
        $past(commit && pt_ctrl.wr_en))
    // A fresh result appears only after a decision cycle.
    `ASSERT_IMPLY(a_result_origin, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_LOOK))

endmodule
